/* design/rpnc_pkg.sv */
// rpnc_pkg: shared types, character codes and constants for the rpn calculator
// used by rpnc_alu, rpn_stack_calculator_unit and rpnc_checker
// no dependencies
package rpnc_pkg;

    localparam int CHAR_W      = 8;
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int FRAC_W      = 16;
    localparam int STEP_W      = 6;
    localparam int MUL_STEPS   = 32;
    localparam int DIV_STEPS   = 48;
    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_INVALID   = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_DIVZERO   = 3'd5
    } rpnc_status_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } rpnc_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_B,
        S_RD_A,
        S_ALU_GO,
        S_ALU_WAIT,
        S_FINISH,
        S_FIN_RD,
        S_EMIT
    } rpnc_state_t;

    typedef enum logic [1:0] {
        AL_IDLE,
        AL_STEP,
        AL_NEG,
        AL_SAT
    } rpnc_alu_state_t;

    typedef struct packed {
        logic     start;
        rpnc_op_t op;
    } rpnc_alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } rpnc_alu_rsp_t;

    function automatic logic is_operator(input logic [CHAR_W-1:0] c);
        return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_STAR) || (c == CHAR_SLASH);
    endfunction

    function automatic rpnc_op_t char_to_op(input logic [CHAR_W-1:0] c);
        rpnc_op_t op;
        priority case (c)
            CHAR_MINUS: op = OP_SUB;
            CHAR_STAR:  op = OP_MUL;
            CHAR_SLASH: op = OP_DIV;
            default:    op = OP_ADD;
        endcase
        return op;
    endfunction

endpackage

/* design/rpnc_ram.sv */
// rpnc_ram: generic single-write, single-read ram with registered read data
// no dependencies
module rpnc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* design/rpnc_alu.sv */
// rpnc_alu: iterative q16.16 add, subtract, multiply and divide around one 33-bit adder
// depends on rpnc_pkg
module rpnc_alu (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rpnc_pkg::rpnc_alu_req_t             req,
    input  logic [rpnc_pkg::DATA_W-1:0]         a,
    input  logic [rpnc_pkg::DATA_W-1:0]         b,
    output rpnc_pkg::rpnc_alu_rsp_t             rsp
);

    rpnc_pkg::rpnc_alu_state_t state_reg, state_next;
    rpnc_pkg::rpnc_op_t        op_reg, op_next;
    logic [31:0]               opa_reg, opa_next;
    logic [31:0]               opb_reg, opb_next;
    logic                      neg_reg, neg_next;
    logic [32:0]               acc_reg, acc_next;
    logic [47:0]               lo_reg, lo_next;
    logic [rpnc_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [63:0]               wide_reg, wide_next;
    logic                      done_reg, done_next;
    logic [31:0]               result_reg, result_next;

    logic        addsub;
    logic [31:0] abs_a;
    logic [31:0] abs_b;
    logic [32:0] add_x;
    logic [32:0] add_y;
    logic        add_sub;
    logic [33:0] add_sum;
    logic [63:0] mag;
    logic [63:0] shifted;

    // shared adder
    assign add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + {33'd0, add_sub};

    assign addsub = (req.op == rpnc_pkg::OP_ADD) || (req.op == rpnc_pkg::OP_SUB);
    assign abs_a  = a[31] ? (~a + 32'd1) : a;
    assign abs_b  = b[31] ? (~b + 32'd1) : b;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpnc_pkg::AL_IDLE:
            begin
                if (req.start)
                begin
                    state_next = rpnc_pkg::AL_STEP;
                end
            end
            rpnc_pkg::AL_STEP:
            begin
                if (cnt_reg == rpnc_pkg::STEP_W'(1))
                begin
                    state_next = rpnc_pkg::AL_NEG;
                end
            end
            rpnc_pkg::AL_NEG:
            begin
                state_next = rpnc_pkg::AL_SAT;
            end
            rpnc_pkg::AL_SAT:
            begin
                state_next = rpnc_pkg::AL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        lo_next     = lo_reg;
        cnt_next    = cnt_reg;
        wide_next   = wide_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        add_x       = '0;
        add_y       = '0;
        add_sub     = 1'b0;
        mag         = '0;
        shifted     = '0;
        unique case (state_reg)
            rpnc_pkg::AL_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    opa_next = addsub ? a : abs_a;
                    opb_next = addsub ? b : abs_b;
                    neg_next = !addsub && (a[31] ^ b[31]);
                    acc_next = '0;
                    lo_next  = (req.op == rpnc_pkg::OP_DIV) ? {abs_a, 16'd0} : {16'd0, abs_b};
                    unique case (req.op)
                        rpnc_pkg::OP_MUL: cnt_next = rpnc_pkg::STEP_W'(rpnc_pkg::MUL_STEPS);
                        rpnc_pkg::OP_DIV: cnt_next = rpnc_pkg::STEP_W'(rpnc_pkg::DIV_STEPS);
                        rpnc_pkg::OP_ADD,
                        rpnc_pkg::OP_SUB: cnt_next = rpnc_pkg::STEP_W'(1);
                    endcase
                end
            end
            rpnc_pkg::AL_STEP:
            begin
                cnt_next = cnt_reg - rpnc_pkg::STEP_W'(1);
                unique case (op_reg)
                    rpnc_pkg::OP_ADD,
                    rpnc_pkg::OP_SUB:
                    begin
                        add_x     = {opa_reg[31], opa_reg};
                        add_y     = {opb_reg[31], opb_reg};
                        add_sub   = (op_reg == rpnc_pkg::OP_SUB);
                        wide_next = {{31{add_sum[32]}}, add_sum[32:0]};
                    end
                    rpnc_pkg::OP_MUL:
                    begin
                        // shift-add, multiplier bits leave from the bottom of lo
                        add_x    = acc_reg;
                        add_y    = lo_reg[0] ? {1'b0, opa_reg} : 33'd0;
                        acc_next = {1'b0, add_sum[32:1]};
                        lo_next  = {lo_reg[47:32], add_sum[0], lo_reg[31:1]};
                    end
                    rpnc_pkg::OP_DIV:
                    begin
                        // restoring division, quotient bits enter at the bottom of lo
                        add_x    = {acc_reg[31:0], lo_reg[47]};
                        add_y    = {1'b0, opb_reg};
                        add_sub  = 1'b1;
                        acc_next = add_sum[33] ? {1'b0, add_sum[31:0]} : {1'b0, add_x[31:0]};
                        lo_next  = {lo_reg[46:0], add_sum[33]};
                    end
                endcase
            end
            rpnc_pkg::AL_NEG:
            begin
                unique case (op_reg)
                    rpnc_pkg::OP_MUL: mag = {acc_reg[31:0], lo_reg[31:0]};
                    rpnc_pkg::OP_DIV: mag = {16'd0, lo_reg};
                    rpnc_pkg::OP_ADD,
                    rpnc_pkg::OP_SUB: mag = wide_reg;
                endcase
                wide_next = neg_reg ? (~mag + 64'd1) : mag;
            end
            rpnc_pkg::AL_SAT:
            begin
                shifted = (op_reg == rpnc_pkg::OP_MUL)
                        ? {{rpnc_pkg::FRAC_W{wide_reg[63]}}, wide_reg[63:rpnc_pkg::FRAC_W]}
                        : wide_reg;
                if ((&shifted[63:31]) || !(|shifted[63:31]))
                begin
                    result_next = shifted[31:0];
                end
                else
                begin
                    result_next = shifted[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end
                done_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpnc_pkg::AL_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        lo_reg     <= lo_next;
        cnt_reg    <= cnt_next;
        wide_reg   <= wide_next;
        result_reg <= result_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

/* design/rpn_stack_calculator_unit.sv */
// rpn_stack_calculator_unit: postfix expression evaluator, one character per request
// depends on rpnc_pkg, rpnc_ram (operand stack) and rpnc_alu (shared arithmetic unit)
//
// channel  dir  tdata                      tuser         tlast
// s_*      in   [7:0] char_code            -             is_last
// m_*      out  [31:0] value (q16.16)      [2:0] status  -
//
// a digit is pushed in S_DECODE; an operator reads both operands, then * and / run the
// one-bit-per-cycle shift-add and restoring divide loops in rpnc_alu
// a tlast request runs S_FINISH, S_FIN_RD (stack bottom read, not on error) and S_EMIT
// s_tready is high only while the sequencer is idle; the output register holds a
// result until taken, and a later result waits for it
// asynchronous active-low reset clears the stack count, error and handshakes
module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = rpnc_pkg::STACK_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rpnc_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] char_code
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rpnc_pkg::DATA_W-1:0]   m_tdata,   // [31:0] value
    output logic [rpnc_pkg::STATUS_W-1:0] m_tuser    // [2:0] status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    rpnc_pkg::rpnc_state_t  state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    rpnc_pkg::rpnc_status_t err_reg, err_next;
    logic [rpnc_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                   last_reg, last_next;
    logic [31:0]            b_reg, b_next;
    logic [31:0]            res_value_reg, res_value_next;
    rpnc_pkg::rpnc_status_t res_status_reg, res_status_next;
    logic                   m_valid_reg, m_valid_next;
    logic [31:0]            m_value_reg, m_value_next;
    rpnc_pkg::rpnc_status_t m_status_reg, m_status_next;

    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [31:0]            ram_wr_data;
    logic [AW-1:0]          ram_rd_addr;
    logic [31:0]            ram_rd_data;
    rpnc_pkg::rpnc_alu_req_t alu_req;
    rpnc_pkg::rpnc_alu_rsp_t alu_rsp;

    logic          is_digit;
    logic          is_op;
    rpnc_pkg::rpnc_op_t op;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] cnt_m2;
    logic [3:0]    digit;
    logic          out_free;

    assign is_digit = (char_reg >= rpnc_pkg::CHAR_ZERO) && (char_reg <= rpnc_pkg::CHAR_NINE);
    assign is_op    = rpnc_pkg::is_operator(char_reg);
    assign op       = rpnc_pkg::char_to_op(char_reg);
    assign cnt_m1   = count_reg - CW'(1);
    assign cnt_m2   = count_reg - CW'(2);
    assign digit    = 4'(char_reg - rpnc_pkg::CHAR_ZERO);
    assign out_free = !m_valid_reg || m_tready;

    rpnc_ram #(
        .WIDTH (rpnc_pkg::DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    rpnc_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (ram_rd_data),
        .b     (b_reg),
        .rsp   (alu_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rpnc_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = rpnc_pkg::S_DECODE;
                end
            end
            rpnc_pkg::S_DECODE:
            begin
                if (err_reg == rpnc_pkg::ST_OK && is_op && count_reg >= CW'(2))
                begin
                    state_next = rpnc_pkg::S_RD_B;
                end
                else
                begin
                    state_next = last_reg ? rpnc_pkg::S_FINISH : rpnc_pkg::S_IDLE;
                end
            end
            rpnc_pkg::S_RD_B:
            begin
                state_next = rpnc_pkg::S_RD_A;
            end
            rpnc_pkg::S_RD_A:
            begin
                if (op == rpnc_pkg::OP_DIV && ram_rd_data == '0)
                begin
                    state_next = last_reg ? rpnc_pkg::S_FINISH : rpnc_pkg::S_IDLE;
                end
                else
                begin
                    state_next = rpnc_pkg::S_ALU_GO;
                end
            end
            rpnc_pkg::S_ALU_GO:
            begin
                state_next = rpnc_pkg::S_ALU_WAIT;
            end
            rpnc_pkg::S_ALU_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    state_next = last_reg ? rpnc_pkg::S_FINISH : rpnc_pkg::S_IDLE;
                end
            end
            rpnc_pkg::S_FINISH:
            begin
                if (err_reg != rpnc_pkg::ST_OK || count_reg != CW'(1))
                begin
                    state_next = rpnc_pkg::S_EMIT;
                end
                else
                begin
                    state_next = rpnc_pkg::S_FIN_RD;
                end
            end
            rpnc_pkg::S_FIN_RD:
            begin
                state_next = rpnc_pkg::S_EMIT;
            end
            rpnc_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = rpnc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rpnc_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        count_next      = count_reg;
        err_next        = err_reg;
        char_next       = char_reg;
        last_next       = last_reg;
        b_next          = b_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = count_reg[AW-1:0];
        ram_wr_data     = {12'd0, digit, 16'd0};
        ram_rd_addr     = '0;
        alu_req.start   = 1'b0;
        alu_req.op      = op;
        s_tready        = 1'b0;
        unique case (state_reg)
            rpnc_pkg::S_IDLE:
            begin
                s_tready  = 1'b1;
                char_next = s_tdata;
                last_next = s_tlast;
            end
            rpnc_pkg::S_DECODE:
            begin
                if (err_reg == rpnc_pkg::ST_OK)
                begin
                    priority if (is_digit)
                    begin
                        if (count_reg == CW'(STACK_DEPTH))
                        begin
                            err_next = rpnc_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            ram_wr_en  = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (is_op)
                    begin
                        if (count_reg < CW'(2))
                        begin
                            err_next = rpnc_pkg::ST_UNDERFLOW;
                        end
                    end
                    else
                    begin
                        err_next = rpnc_pkg::ST_INVALID;
                    end
                end
            end
            rpnc_pkg::S_RD_B:
            begin
                ram_rd_addr = cnt_m1[AW-1:0];
            end
            rpnc_pkg::S_RD_A:
            begin
                ram_rd_addr = cnt_m2[AW-1:0];
                b_next      = ram_rd_data;
                if (op == rpnc_pkg::OP_DIV && ram_rd_data == '0)
                begin
                    err_next = rpnc_pkg::ST_DIVZERO;
                end
            end
            rpnc_pkg::S_ALU_GO:
            begin
                alu_req.start = 1'b1;
            end
            rpnc_pkg::S_ALU_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = cnt_m2[AW-1:0];
                    ram_wr_data = alu_rsp.result;
                    count_next  = cnt_m1;
                end
            end
            rpnc_pkg::S_FINISH:
            begin
                res_value_next = '0;
                if (err_reg != rpnc_pkg::ST_OK)
                begin
                    res_status_next = err_reg;
                end
                else if (count_reg != CW'(1))
                begin
                    res_status_next = rpnc_pkg::ST_MISMATCH;
                end
                else
                begin
                    res_status_next = rpnc_pkg::ST_OK;
                end
            end
            rpnc_pkg::S_FIN_RD:
            begin
                res_value_next = ram_rd_data;
            end
            rpnc_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    count_next    = '0;
                    err_next      = rpnc_pkg::ST_OK;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rpnc_pkg::S_IDLE;
            count_reg   <= '0;
            err_reg     <= rpnc_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg       <= char_next;
        last_reg       <= last_next;
        b_reg          <= b_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_value_reg;
    assign m_tuser  = m_status_reg;

endmodule

/* design/rpnc_checker.sv */
// rpnc_checker: port-level checks for rpn_stack_calculator_unit, attached by bind
// depends on rpnc_pkg
module rpnc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rpnc_pkg::CHAR_W-1:0]   s_tdata,
    input logic                          s_tlast,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rpnc_pkg::DATA_W-1:0]   m_tdata,
    input logic [rpnc_pkg::STATUS_W-1:0] m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // failed expressions give a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != rpnc_pkg::ST_OK) |-> m_tdata == '0)
        else $error("nonzero value with error status");

    // status code range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= rpnc_pkg::ST_DIVZERO)
        else $error("status code out of range");

    // block is not ready right after each request
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after a request");

    // a result is never raised right after a request without tlast
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> !$rose(m_tvalid))
        else $error("result raised right after a non-final request");

endmodule

bind rpn_stack_calculator_unit rpnc_checker u_rpnc_checker (.*);
